[design/cre_pkg.sv]
// Shared types and constants of the Catmull-Rom point evaluator.
package cre_pkg;

    // Signed Q8.8 coordinate and a point of three of them (index 0 is x).
    typedef logic signed [15:0] coord_t;
    typedef coord_t [2:0] point_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_POINT = 2'd0,
        ST_LOAD  = 2'd1,
        ST_RANGE = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    // One classified item on its way from the front part to the back part.
    // p[0] .. p[3] are the control points i-1, i, i+1 and i+2.
    typedef struct packed {
        status_t         status;
        logic [16:0]     u;
        point_t [3:0]    p;
    } item_t;

    localparam logic [16:0] U_ONE = 17'd65536;
    localparam int U_FRAC   = 16;
    localparam int TAU_FRAC = 12;
    localparam int TAU_ONE  = 4096;
    localparam int TWO_Q    = 2 * TAU_ONE;
    localparam int THREE_Q  = 3 * TAU_ONE;

    // Coefficient and accumulator width, and Horner product width.
    localparam int CW = 36;
    localparam int PW = CW + 18;

    localparam int QDEPTH = 4;

endpackage

[design/cre_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cre_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/cre_front.sv]
// Front part: accepts items, stores loads, classifies and fetches the four points.
module cre_front
    import cre_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  point_count,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [2:0]  point_index,
    input  coord_t      load_x,
    input  coord_t      load_y,
    input  coord_t      load_z,
    input  logic [16:0] param_u,
    input  logic        q_full,
    output logic        push,
    output item_t       push_item
);

    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int XW = NW + 1;
    localparam int AW = $clog2(MAX_POINTS);

    logic              accept;
    logic [XW-1:0]     n_x;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     s1_x;
    logic [XW-1:0]     s2_x;
    logic [XW-1:0]     addr_x [4];
    logic              load_ok;
    logic              eval_ok;
    point_t            wpt;
    point_t            rd_pt [4];
    status_t           status_next;
    logic [16:0]       u_next;

    logic              f1_vld_reg;
    status_t           f1_status_reg;
    logic [16:0]       f1_u_reg;

    assign in_stall = f1_vld_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = f1_vld_reg && !q_full;

    // Ring size clamped to the range that the store can hold.
    always_comb
    begin
        if (point_count == 4'd0)
        begin
            n_x = XW'(1);
        end
        else if (int'(point_count) > MAX_POINTS)
        begin
            n_x = XW'(MAX_POINTS);
        end
        else
        begin
            n_x = XW'(point_count);
        end
    end

    assign idx_x   = XW'(point_index);
    assign s1_x    = idx_x + XW'(1);
    assign s2_x    = idx_x + XW'(2);
    assign load_ok = int'(point_index) < MAX_POINTS;
    assign eval_ok = idx_x < n_x;

    // Neighbor slots wrap around the ring; a ring of one point uses it four times.
    always_comb
    begin
        addr_x[0] = (idx_x == '0) ? n_x - XW'(1) : idx_x - XW'(1);
        addr_x[1] = idx_x;
        addr_x[2] = (s1_x >= n_x) ? s1_x - n_x : s1_x;
        if (n_x == XW'(1))
        begin
            addr_x[3] = '0;
        end
        else
        begin
            addr_x[3] = (s2_x >= n_x) ? s2_x - n_x : s2_x;
        end
    end

    always_comb
    begin
        wpt[0] = load_x;
        wpt[1] = load_y;
        wpt[2] = load_z;
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_copy
        cre_ram #(
            .WIDTH ($bits(point_t)),
            .DEPTH (MAX_POINTS)
        ) u_ram (
            .clk   (clk),
            .we    (accept && (op == OP_LOAD) && load_ok),
            .waddr (AW'(point_index)),
            .wdata (wpt),
            .re    (accept),
            .raddr (addr_x[k][AW-1:0]),
            .rdata (rd_pt[k])
        );
    end

    always_comb
    begin
        if (op == OP_LOAD)
        begin
            status_next = load_ok ? ST_LOAD : ST_RANGE;
        end
        else
        begin
            status_next = eval_ok ? ST_POINT : ST_RANGE;
        end
        u_next = (param_u > U_ONE) ? U_ONE : param_u;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            f1_vld_reg <= 1'b1;
        end
        else if (push)
        begin
            f1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_status_reg <= status_next;
            f1_u_reg      <= u_next;
        end
    end

    always_comb
    begin
        push_item.status = f1_status_reg;
        push_item.u      = f1_u_reg;
        push_item.p[0]   = rd_pt[0];
        push_item.p[1]   = rd_pt[1];
        push_item.p[2]   = rd_pt[2];
        push_item.p[3]   = rd_pt[3];
    end

endmodule

[design/cre_fifo.sv]
// Short item queue between the front and back parts.
module cre_fifo
    import cre_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output item_t head,
    output logic  empty
);

    localparam int QAW = $clog2(QDEPTH);

    item_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   head_reg;
    logic [QAW-1:0]   tail_reg;
    logic [QAW:0]     count_reg;

    assign full  = count_reg == (QAW + 1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[head_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                tail_reg <= tail_reg + QAW'(1);
            end
            if (pop)
            begin
                head_reg <= head_reg + QAW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + (QAW + 1)'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - (QAW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_item;
        end
    end

endmodule

[design/cre_back.sv]
// Back part: coefficient and Horner pipeline, one lane per axis, plus the output register.
module cre_back
    import cre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [14:0] tension,
    input  item_t       head,
    input  logic        q_empty,
    output logic        pop,
    input  logic        out_stall,
    output logic        out_valid,
    output point_t      out_pt,
    output status_t     status
);

    localparam int NST = 9;
    localparam int D1W = 17;
    localparam int D2W = 19;
    localparam int D3W = 18;
    localparam logic signed [PW-1:0] HALF_U = PW'(1) <<< (U_FRAC - 1);
    localparam logic signed [CW-1:0] HALF_T = CW'(1) <<< (TAU_FRAC - 1);
    localparam logic signed [CW-1:0] SAT_HI = CW'(32767);
    localparam logic signed [CW-1:0] SAT_LO = -CW'(32768);

    // round(p / 2^16), ties toward plus infinity.
    function automatic logic signed [CW-1:0] round_u(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + HALF_U;
        return CW'(s >>> U_FRAC);
    endfunction

    logic                 adv;
    logic                 vld_reg [NST];
    status_t              st_reg  [NST];
    logic [16:0]          u_reg   [NST];
    logic signed [CW-1:0] t_w;
    logic signed [PW-1:0] uw2;
    logic signed [PW-1:0] uw4;
    logic signed [PW-1:0] uw6;
    coord_t               lane_res [3];
    logic [2:0]           lane_sat;

    logic                 out_vld_reg;
    status_t              out_st_reg;
    point_t               out_pt_reg;

    // The whole pipeline moves together unless a finished item waits at the output.
    assign adv = !out_vld_reg || !out_stall;
    assign pop = adv && !q_empty;

    assign t_w = CW'($signed({1'b0, tension}));
    assign uw2 = PW'($signed({1'b0, u_reg[2]}));
    assign uw4 = PW'($signed({1'b0, u_reg[4]}));
    assign uw6 = PW'($signed({1'b0, u_reg[6]}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= pop;
            for (int k = 1; k < NST; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st_reg[0] <= head.status;
            u_reg[0]  <= head.u;
            for (int k = 1; k < NST; k++)
            begin
                st_reg[k] <= st_reg[k-1];
                u_reg[k]  <= u_reg[k-1];
            end
        end
    end

    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        coord_t                p0;
        coord_t                p1;
        coord_t                p2;
        coord_t                p3;
        logic signed [D1W-1:0] d1_reg;
        logic signed [D2W-1:0] d2_reg;
        logic signed [D3W-1:0] d3_reg;
        logic signed [D1W-1:0] e2_reg;
        coord_t                p1_reg;
        logic signed [CW-1:0]  m1_reg;
        logic signed [CW-1:0]  m2_reg;
        logic signed [CW-1:0]  m3_reg;
        logic signed [D1W-1:0] e2b_reg;
        coord_t                p1b_reg;
        logic signed [CW-1:0]  c0_reg;
        logic signed [CW-1:0]  c1_reg;
        logic signed [CW-1:0]  c2_reg;
        logic signed [CW-1:0]  c3_reg;
        logic signed [PW-1:0]  pr3_reg;
        logic signed [CW-1:0]  c2_3_reg;
        logic signed [CW-1:0]  c1_3_reg;
        logic signed [CW-1:0]  c0_3_reg;
        logic signed [CW-1:0]  acc4_reg;
        logic signed [CW-1:0]  c1_4_reg;
        logic signed [CW-1:0]  c0_4_reg;
        logic signed [PW-1:0]  pr5_reg;
        logic signed [CW-1:0]  c1_5_reg;
        logic signed [CW-1:0]  c0_5_reg;
        logic signed [CW-1:0]  acc6_reg;
        logic signed [CW-1:0]  c0_6_reg;
        logic signed [PW-1:0]  pr7_reg;
        logic signed [CW-1:0]  c0_7_reg;
        logic signed [CW-1:0]  acc8_reg;
        logic signed [CW-1:0]  r_w;

        assign p0 = head.p[0][a];
        assign p1 = head.p[1][a];
        assign p2 = head.p[2][a];
        assign p3 = head.p[3][a];

        // Each of c1 to c3 is tau times a sum of points plus a fixed multiple of
        // p2 - p1 (c0 is p1 scaled), so one tension product per coefficient suffices.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d1_reg   <= D1W'(p2) - D1W'(p0);
                d2_reg   <= D2W'(p0) + D2W'(p0) + D2W'(p1) - D2W'(p2) - D2W'(p2) - D2W'(p3);
                d3_reg   <= D3W'(p2) + D3W'(p3) - D3W'(p0) - D3W'(p1);
                e2_reg   <= D1W'(p2) - D1W'(p1);
                p1_reg   <= p1;

                m1_reg   <= t_w * CW'(d1_reg);
                m2_reg   <= t_w * CW'(d2_reg);
                m3_reg   <= t_w * CW'(d3_reg);
                e2b_reg  <= e2_reg;
                p1b_reg  <= p1_reg;

                c3_reg   <= m3_reg - CW'(e2b_reg) * TWO_Q;
                c2_reg   <= m2_reg + CW'(e2b_reg) * THREE_Q;
                c1_reg   <= m1_reg;
                c0_reg   <= CW'(p1b_reg) <<< TAU_FRAC;

                pr3_reg  <= PW'(c3_reg) * uw2;
                c2_3_reg <= c2_reg;
                c1_3_reg <= c1_reg;
                c0_3_reg <= c0_reg;

                acc4_reg <= c2_3_reg + round_u(pr3_reg);
                c1_4_reg <= c1_3_reg;
                c0_4_reg <= c0_3_reg;

                pr5_reg  <= PW'(acc4_reg) * uw4;
                c1_5_reg <= c1_4_reg;
                c0_5_reg <= c0_4_reg;

                acc6_reg <= c1_5_reg + round_u(pr5_reg);
                c0_6_reg <= c0_5_reg;

                pr7_reg  <= PW'(acc6_reg) * uw6;
                c0_7_reg <= c0_6_reg;

                acc8_reg <= c0_7_reg + round_u(pr7_reg);
            end
        end

        assign r_w = (acc8_reg + HALF_T) >>> TAU_FRAC;

        always_comb
        begin
            if (r_w > SAT_HI)
            begin
                lane_res[a] = 16'sh7FFF;
                lane_sat[a] = 1'b1;
            end
            else if (r_w < SAT_LO)
            begin
                lane_res[a] = 16'sh8000;
                lane_sat[a] = 1'b1;
            end
            else
            begin
                lane_res[a] = coord_t'(r_w[15:0]);
                lane_sat[a] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (st_reg[NST-1] == ST_POINT)
            begin
                out_st_reg    <= (|lane_sat) ? ST_SAT : ST_POINT;
                out_pt_reg[0] <= lane_res[0];
                out_pt_reg[1] <= lane_res[1];
                out_pt_reg[2] <= lane_res[2];
            end
            else
            begin
                out_st_reg <= st_reg[NST-1];
                out_pt_reg <= '0;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_pt    = out_pt_reg;
    assign status    = out_st_reg;

endmodule

[design/catmull_rom_point_evaluator.sv]
// Top level of the Catmull-Rom point evaluator: register port and the three parts.
//
// The block holds a closed ring of up to MAX_POINTS control points (x, y, z in signed
// Q8.8) and evaluates a Catmull-Rom spline with tension tau at parameter u. An item with
// op load writes one point at point_index and answers with status "load done"; an item
// with op evaluate takes points i-1, i, i+1 and i+2 around the ring of point_count points
// and answers with the curve point, saturated to Q8.8 (status "saturated" when any axis
// clipped). An index beyond the ring gives status "out of range" and zero coordinates.
// Every item gives exactly one result item, in order. The block takes one item per clock
// cycle for as long as results are taken; the result of an item passes through the front
// register, the queue and a nine-stage back pipeline (point differences, a tension
// multiply, coefficient forming, then three multiply-and-round steps
// of Horner's rule) ending in the output register. The control store is four copies of
// one small RAM, so all four neighbors are read in the cycle an item is accepted; a load
// followed at once by an evaluation sees the new point with no wait. Control points read
// back anything until written, and there is no clearing pass after reset. The point_count
// and tension registers sit at byte addresses 0 and 4 and may only be written while no
// item is in flight.
module catmull_rom_point_evaluator
    import cre_pkg::*;
#(
    parameter int MAX_POINTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [2:0]  point_index,
    input  logic signed [15:0] load_x,
    input  logic signed [15:0] load_y,
    input  logic signed [15:0] load_z,
    input  logic [16:0] param_u,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic [1:0]  status
);

    localparam logic [0:0] REG_POINT_COUNT = 1'b0;
    localparam logic [0:0] REG_TENSION     = 1'b1;

    logic        cfg_wr;
    logic [0:0]  reg_idx;
    logic [3:0]  point_count_reg;
    logic [14:0] tension_reg;

    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        pop;
    item_t       push_item;
    item_t       head;
    point_t      out_pt;

    // Register port: the write lands in the access phase; reads return the register.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= 4'd8;
            tension_reg     <= 15'd2048;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_POINT_COUNT: point_count_reg <= pwdata[3:0];
                REG_TENSION:     tension_reg     <= pwdata[14:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_POINT_COUNT: prdata = {28'd0, point_count_reg};
            REG_TENSION:     prdata = {17'd0, tension_reg};
            default:         prdata = '0;
        endcase
    end

    // The front part stores loads and fetches the neighbors of each evaluation.
    cre_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_count (point_count_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .point_index (point_index),
        .load_x      (load_x),
        .load_y      (load_y),
        .load_z      (load_z),
        .param_u     (param_u),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    // The queue lets the front keep accepting while the back waits on its output.
    cre_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    cre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tension   (tension_reg),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_pt    (out_pt),
        .status    (status)
    );

    assign out_x = out_pt[0];
    assign out_y = out_pt[1];
    assign out_z = out_pt[2];

endmodule

[design/cre_checker.sv]
// Port-level assertions for the Catmull-Rom point evaluator and their binding.
module cre_checker
    import cre_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] out_x,
    input logic signed [15:0] out_y,
    input logic signed [15:0] out_z,
    input logic [1:0]         status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
            && $stable(status))
        else $error("stalled result item changed");

    // Load answers and rejected items carry no coordinates.
    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_LOAD || status == ST_RANGE)
            |-> out_x == 16'sd0 && out_y == 16'sd0 && out_z == 16'sd0)
        else $error("non-point result item with nonzero coordinates");

    // A saturated point has at least one axis at a limit of the Q8.8 range.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SAT
            |-> out_x == 16'sh7FFF || out_x == 16'sh8000 || out_y == 16'sh7FFF
                || out_y == 16'sh8000 || out_z == 16'sh7FFF || out_z == 16'sh8000)
        else $error("saturated status without a clipped axis");

endmodule

bind catmull_rom_point_evaluator cre_checker u_cre_checker (.*);

[sim/tb.sv]
// Self-checking testbench for the Catmull-Rom point evaluator.
module tb
    import cre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_POINTS = 8;
    // Settling time after the last result before a register write; leave a little margin.
    localparam int SETTLE_CYCLES = 16;
    // Cycles with no item moved on either channel before the run is abandoned.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;

    // Register byte addresses on the configuration port.
    localparam logic [2:0] REG_POINT_COUNT = 3'd0;
    localparam logic [2:0] REG_TENSION     = 3'd4;

    // One input item as the sender offers it.
    typedef struct {
        op_t         op;
        logic [2:0]  idx;
        coord_t      x;
        coord_t      y;
        coord_t      z;
        logic [16:0] u;
    } spline_req_t;

    // One result item as the block should return it.
    typedef struct {
        coord_t  x;
        coord_t  y;
        coord_t  z;
        status_t st;
    } curve_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               op = 1'b0;
    logic [2:0]         point_index = '0;
    logic signed [15:0] load_x = '0;
    logic signed [15:0] load_y = '0;
    logic signed [15:0] load_z = '0;
    logic [16:0]        param_u = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic [1:0]         status;

    catmull_rom_point_evaluator #(
        .MAX_POINTS(MAX_POINTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .point_index(point_index),
        .load_x(load_x),
        .load_y(load_y),
        .load_z(load_z),
        .param_u(param_u),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_x(out_x),
        .out_y(out_y),
        .out_z(out_z),
        .status(status)
    );

    always #6 clk = ~clk;

    // Items waiting to be offered, and curve points waiting to come back.
    spline_req_t  pending_items[$];
    curve_point_t awaited_points[$];

    // The testbench's own copy of the control point ring and the two registers.
    coord_t     ring_pts[0:MAX_POINTS-1][0:2];
    logic [3:0] ring_count = 4'd8;
    logic [14:0] tau_q = 15'd2048;

    // Idle rates in percent for each side; the main sequence changes them per phase.
    int send_idle_pct = 19;
    int recv_idle_pct = 19;
    // A request for a long receiver hold-off, taken over by the receiver process.
    int hold_req = 0;
    int hold_left = 0;

    bit in_taken = 1'b0;
    int errors = 0;
    int reports = 0;
    int quiet_cycles = 0;
    int n_loads = 0;
    int n_evals = 0;
    int n_range = 0;
    int n_sat = 0;
    int n_settings = 0;

    // Round to nearest with ties toward plus infinity; an arithmetic shift of the
    // biased value is a floor, which is exactly that rounding.
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Works out the result of one accepted item and applies its effect on the ring.
    function automatic curve_point_t predict_point(spline_req_t r);
        curve_point_t res;
        int n;
        int nb[0:3];
        longint p[0:3];
        longint t, uu, c0, c1, c2, c3, acc, v;
        coord_t axis_val[0:2];
        bit clipped;
        res.x = '0;
        res.y = '0;
        res.z = '0;
        n = (ring_count < 1) ? 1 : (ring_count > MAX_POINTS) ? MAX_POINTS : int'(ring_count);
        if (r.op == OP_LOAD)
        begin
            // Every 3-bit index is a valid slot, so a load always lands.
            ring_pts[r.idx][0] = r.x;
            ring_pts[r.idx][1] = r.y;
            ring_pts[r.idx][2] = r.z;
            res.st = ST_LOAD;
            return res;
        end
        if (int'(r.idx) >= n)
        begin
            res.st = ST_RANGE;
            return res;
        end
        nb[0] = (int'(r.idx) + n - 1) % n;
        nb[1] = int'(r.idx);
        nb[2] = (int'(r.idx) + 1) % n;
        nb[3] = (int'(r.idx) + 2) % n;
        t = longint'(tau_q);
        uu = (r.u > U_ONE) ? longint'(U_ONE) : longint'(r.u);
        clipped = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            for (int k = 0; k < 4; k++)
                p[k] = longint'(ring_pts[nb[k]][a]);
            c0 = p[1] * TAU_ONE;
            c1 = -t * p[0] + t * p[2];
            c2 = 2 * t * p[0] + (t - THREE_Q) * p[1] + (THREE_Q - 2 * t) * p[2] - t * p[3];
            c3 = -t * p[0] + (TWO_Q - t) * p[1] + (t - TWO_Q) * p[2] + t * p[3];
            // Horner's rule, rounding after each multiply by u.
            acc = c3;
            acc = c2 + round_shift(acc * uu, U_FRAC);
            acc = c1 + round_shift(acc * uu, U_FRAC);
            acc = c0 + round_shift(acc * uu, U_FRAC);
            v = round_shift(acc, TAU_FRAC);
            if (v > 32767)
            begin
                v = 32767;
                clipped = 1'b1;
            end
            else if (v < -32768)
            begin
                v = -32768;
                clipped = 1'b1;
            end
            axis_val[a] = coord_t'(v);
        end
        res.x = axis_val[0];
        res.y = axis_val[1];
        res.z = axis_val[2];
        res.st = clipped ? ST_SAT : ST_POINT;
        return res;
    endfunction

    // Input side: an item is taken at a rising edge with valid high and stall low.
    // The prediction is made right here, so it sees the ring and registers in the
    // same order as the block does, including a load directly before an evaluation.
    always @(posedge clk)
    begin
        spline_req_t r;
        curve_point_t e;
        if (rst_n && in_valid && !in_stall)
        begin
            r.op = op_t'(op);
            r.idx = point_index;
            r.x = load_x;
            r.y = load_y;
            r.z = load_z;
            r.u = param_u;
            e = predict_point(r);
            awaited_points.insert(awaited_points.size(), e);
            if (r.op == OP_LOAD)
                n_loads++;
            else
                n_evals++;
            if (e.st == ST_RANGE)
                n_range++;
            if (e.st == ST_SAT)
                n_sat++;
            in_taken = 1'b1;
        end
    end

    // Driver: on the falling edge either keeps a stalled item steady or offers the
    // next one. Idle gaps are drawn at random and never look at the stall.
    always @(negedge clk)
    begin
        spline_req_t r;
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                r = pending_items.pop_front();
                op <= r.op;
                point_index <= r.idx;
                load_x <= r.x;
                load_y <= r.y;
                load_z <= r.z;
                param_u <= r.u;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall: random stalls, or a long hold-off counted here when requested.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Output side: each result taken is compared with the oldest expectation.
    always @(posedge clk)
    begin
        curve_point_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_points.size() == 0)
            begin
                errors++;
                if (reports < 10)
                begin
                    reports++;
                    $display("Unexpected result: x=%0d y=%0d z=%0d status=%0d",
                             out_x, out_y, out_z, status);
                end
            end
            else
            begin
                e = awaited_points.pop_front();
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z || status !== e.st)
                begin
                    errors++;
                    if (reports < 10)
                    begin
                        reports++;
                        $display("Mismatch: expected x=%0d y=%0d z=%0d %s,",
                                 e.x, e.y, e.z, e.st.name(),
                                 " got x=%0d y=%0d z=%0d status=%0d",
                                 out_x, out_y, out_z, status);
                    end
                end
            end
        end
    end

    // Watchdog: abandons the run if neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
                $display("FAIL catmull_rom_point_evaluator");
                $finish;
            end
        end
    end

    // Register write in a setup and an access cycle, then a read-back of the value.
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val,
                             input logic [31:0] mask);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        pwrite = 1'b0;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== (val & mask))
        begin
            errors++;
            if (reports < 10)
            begin
                reports++;
                $display("Register at %0d reads %0h, written %0h", addr, prdata, val & mask);
            end
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Waits until every item is sent and every result is back, then lets the
    // pipeline settle so that a register write finds the block idle.
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || awaited_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_ring(input int count, input int tau);
        reg_write(REG_POINT_COUNT, 32'(count), 32'hF);
        reg_write(REG_TENSION, 32'(tau), 32'h7FFF);
        ring_count = 4'(count);
        tau_q = 15'(tau);
        n_settings++;
    endtask

    task automatic push_load(input int idx, input int x, input int y, input int z);
        spline_req_t r;
        r.op = OP_LOAD;
        r.idx = 3'(idx);
        r.x = coord_t'(x);
        r.y = coord_t'(y);
        r.z = coord_t'(z);
        // The u field is ignored by a load, so fill it with noise.
        r.u = 17'($urandom);
        pending_items.insert(pending_items.size(), r);
    endtask

    task automatic push_eval(input int idx, input int u);
        spline_req_t r;
        r.op = OP_EVAL;
        r.idx = 3'(idx);
        r.x = coord_t'($urandom);
        r.y = coord_t'($urandom);
        r.z = coord_t'($urandom);
        r.u = 17'(u);
        pending_items.insert(pending_items.size(), r);
    endtask

    // Coordinates: extremes now and then, full-range values, and small values
    // that keep the curve inside range so that plain results are common too.
    function automatic int rand_coord();
        int m;
        m = $urandom_range(9);
        if (m < 2)
        begin
            case ($urandom_range(3))
                0: return 32767;
                1: return -32768;
                2: return 0;
                default: return -1;
            endcase
        end
        if (m < 6)
            return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(4095)) - 2048;
    endfunction

    function automatic int rand_u();
        int m;
        m = $urandom_range(19);
        if (m == 0)
            return 0;
        if (m == 1)
            return 65536;
        if (m < 4)
            return $urandom_range(131071);
        return $urandom_range(65536);
    endfunction

    // A random phase: mostly evaluations inside the ring, some anywhere, and loads
    // that keep changing the points under the evaluations.
    task automatic push_random(input int count);
        int n;
        int pick;
        n = (ring_count < 1) ? 1 : (ring_count > MAX_POINTS) ? MAX_POINTS : int'(ring_count);
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                push_load($urandom_range(MAX_POINTS - 1), rand_coord(), rand_coord(),
                          rand_coord());
            else if (pick < 90)
                push_eval($urandom_range(n - 1), rand_u());
            else
                push_eval($urandom_range(7), rand_u());
        end
    endtask

    // One random phase under a new register setting. Draining first means the
    // sender pauses until every expected result has come before the write.
    task automatic random_phase(input int count, input int tau, input int items,
                                input int snd_idle, input int rcv_idle, input int hold);
        wait_drained();
        set_ring(count, tau);
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        push_random(items);
        if (hold > 0)
            hold_req = hold;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings (eight points, tension one half).
        // Every slot is loaded first, so no evaluation ever reads an unwritten point.
        push_load(0, 32767, -32768, 0);
        push_load(1, -32768, 32767, 256);
        push_load(2, 32767, -32768, -1);
        push_load(3, -32768, 32767, 1);
        push_load(4, 256, 512, 768);
        push_load(5, -256, -512, -768);
        push_load(6, 4660, -4660, 28672);
        push_load(7, -1, 1, 21845);
        // Segment ends, wrap-around on both sides, u of zero and one, u above one.
        push_eval(0, 0);
        push_eval(7, 65536);
        push_eval(1, 32768);
        push_eval(3, 131071);
        push_eval(4, 1);
        push_eval(6, 65535);
        // A load directly followed by evaluations that read the new point.
        push_load(5, 1, 2, 3);
        push_eval(5, 16384);
        push_eval(4, 49152);

        // Short ring with a tension far above the usual range, and indices past the ring.
        wait_drained();
        set_ring(3, 32767);
        push_eval(0, 40000);
        push_eval(2, 65536);
        push_eval(3, 1000);
        push_eval(7, 65536);
        push_load(6, -32768, -32768, -32768);
        push_eval(1, 20000);

        // Random phases across the register range; one holds off the receiver for a
        // long stretch while the sender keeps offering, another runs with no idling.
        random_phase(8, 2048, 80, 19, 19, 0);
        random_phase(0, 16384, 55, 19, 19, 0);
        random_phase(15, 0, 60, 19, 19, 0);
        random_phase(5, 4096, 80, 0, 19, HOLD_CYCLES);
        random_phase(1, 1024, 45, 19, 19, 0);
        random_phase(8, 32767, 70, 0, 0, 0);
        random_phase(4, 6000, 60, 19, 19, 0);
        wait_drained();

        $display("Covered %0d loads and %0d evaluations under %0d ring and tension settings,",
                 n_loads, n_evals, n_settings);
        $display("including %0d out-of-range and %0d saturated results.", n_range, n_sat);
        if (errors == 0 && awaited_points.size() == 0)
        begin
            $display("PASS catmull_rom_point_evaluator");
        end
        else
        begin
            $display("%0d failures", errors + awaited_points.size());
            $display("FAIL catmull_rom_point_evaluator");
        end
        $finish;
    end

endmodule

[files.f]
design/cre_pkg.sv
design/cre_ram.sv
design/cre_front.sv
design/cre_fifo.sv
design/cre_back.sv
design/catmull_rom_point_evaluator.sv
design/cre_checker.sv
sim/tb.sv
